// File: hdl/byte_ring_fifo_with_search_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the byte ring FIFO with search
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_FIFO_WITH_SEARCH_UNIT_ASSERT_SVH
`define BYTE_RING_FIFO_WITH_SEARCH_UNIT_ASSERT_SVH

// A condition that must hold in every cycle out of reset.
`define BRFS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("brfs: invariant violated");

// When the trigger holds, the consequence holds in the same cycle.
`define BRFS_ASSERT_SAME(label, clk, rst_n, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
		else $error("brfs: same-cycle implication violated");

// When the trigger holds, the consequence holds in the next cycle.
`define BRFS_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
		else $error("brfs: next-cycle implication violated");

`endif

// File: hdl/brfs_pkg.sv
// ----------------------------------------------------------------------------
// brfs_pkg
// Constants, codes and helpers of the byte ring FIFO with search.
// ----------------------------------------------------------------------------
package brfs_pkg;

	localparam int DEPTH     = 256;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int LEN_W     = ADDR_W + 1;
	localparam int MAX_BYTES = 8;
	localparam int CNT_W     = 4;
	localparam int DATA_W    = 8 * MAX_BYTES;

	localparam logic [1:0] CMD_PUT  = 2'd0;
	localparam logic [1:0] CMD_GET  = 2'd1;
	localparam logic [1:0] CMD_FIND = 2'd2;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_OVERFLOW = 2'd1;
	localparam logic [1:0] STAT_NOTFOUND = 2'd2;
	localparam logic [1:0] STAT_ZERO_LEN = 2'd3;

	localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);
	localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(DEPTH);
	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(256);

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [LEN_W-1:0]  len_t;

	// Step a pointer by one slot, wrapping at the active length.
	function automatic addr_t ptr_next(addr_t p, len_t len);
		len_t s;
		s = {1'b0, p} + len_t'(1);
		return (s >= len) ? addr_t'(0) : s[ADDR_W-1:0];
	endfunction

	// Clamp the configured length to the legal slot range.
	function automatic len_t len_clamp(len_t raw);
		if (raw < LEN_MIN) begin
			return LEN_MIN;
		end else if (raw > LEN_MAX) begin
			return LEN_MAX;
		end
		return raw;
	endfunction

endpackage

// File: hdl/byte_ring_fifo_with_search_unit.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_search_unit
// Circular byte FIFO over one synchronous RAM with put, get and pattern find.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake              Fields
// command  in   start high, busy low   cmd, payload, byte_count
// result   out  done, one cycle        status, read_bytes, bytes_read, match_offset, fill_level
// config   in   cfg_we high            cfg_wdata (buffer length)
//
// Each command transfer yields exactly one result transfer. Put writes the payload bytes in turn,
// get reads the stored bytes through the registered RAM read, and find streams up to the fill
// level of stored bytes from the tail, stopping at the first match.
// Commands that fail at once, and the unused command, report in the cycle after the transfer.
// The asynchronous reset empties the FIFO and sets the length to 256; the RAM is not cleared.
// The receiver cannot stall results, so busy is the only back pressure.
//
module byte_ring_fifo_with_search_unit
	import brfs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        cmd,
	input  logic [DATA_W-1:0] payload,
	input  logic [CNT_W-1:0]  byte_count,
	output logic              done,
	output logic [1:0]        status,
	output logic [DATA_W-1:0] read_bytes,
	output logic [CNT_W-1:0]  bytes_read,
	output logic [ADDR_W-1:0] match_offset,
	output logic [ADDR_W-1:0] fill_level,
	input  logic              cfg_we,
	input  logic [LEN_W-1:0]  cfg_wdata
);

	// Sequencer states.
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_PUT  = 2'd1;
	localparam logic [1:0] S_GET  = 2'd2;
	localparam logic [1:0] S_FIND = 2'd3;

	logic [1:0]        state_q;
	len_t              len_q;
	addr_t             wp_q;
	addr_t             rp_q;
	addr_t             fill_q;
	addr_t             addr_q;
	addr_t             iss_q;
	addr_t             k_q;
	logic [CNT_W-1:0]  n_q;
	logic [DATA_W-1:0] pat_q;
	logic [DATA_W-1:0] acc_q;
	logic [7:0]        win_q [MAX_BYTES];

	logic              done_q;
	logic [1:0]        status_q;
	logic [DATA_W-1:0] read_bytes_q;
	logic [CNT_W-1:0]  bytes_read_q;
	addr_t             match_offset_q;
	addr_t             fill_level_q;

	// The byte store: one port, read data registered.
	logic [7:0]        mem [DEPTH];
	addr_t             mem_addr;
	logic              mem_we;
	logic [7:0]        rdata_s1;
	logic              valid_s1;

	len_t              len_eff;
	logic [CNT_W-1:0]  n_eff;
	logic [CNT_W-1:0]  get_n;
	len_t              room;
	logic              issue;
	logic              accept;
	logic [7:0]        win_nx [MAX_BYTES];
	logic              win_match;
	len_t              k_inc;
	logic [DATA_W-1:0] acc_nx;
	logic [CNT_W-1:0]  k_next;

	assign len_eff = len_clamp(len_q);
	assign n_eff   = (byte_count > CNT_W'(MAX_BYTES)) ? CNT_W'(MAX_BYTES) : byte_count;
	assign get_n   = ({4'b0, n_eff} < fill_q) ? n_eff : fill_q[CNT_W-1:0];
	assign room    = len_eff - len_t'(1) - {1'b0, fill_q};
	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign issue   = (state_q inside {S_GET, S_FIND}) && (iss_q != addr_t'(0));
	assign k_inc   = {1'b0, k_q} + len_t'(1);
	assign k_next  = k_inc[CNT_W-1:0];

	assign mem_addr = (state_q == S_PUT) ? wp_q : addr_q;
	assign mem_we   = (state_q == S_PUT);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= pat_q[7:0];
		end
		rdata_s1 <= mem[mem_addr];
	end

	// The newest stored byte enters the window at the front. A match needs the
	// newest byte to equal the last pattern byte, the one before it the byte
	// before that, and so on for the pattern length.
	always_comb begin
		logic [CNT_W-1:0] idx;
		win_match = 1'b1;
		for (int j = 0; j < MAX_BYTES; j++) begin
			win_nx[j] = (j == 0) ? rdata_s1 : win_q[(j == 0) ? 0 : j - 1];
		end
		for (int j = 0; j < MAX_BYTES; j++) begin
			idx = n_q - CNT_W'(1) - CNT_W'(j);
			if (CNT_W'(j) < n_q) begin
				if (win_nx[j] != pat_q[8 * idx[2:0] +: 8]) begin
					win_match = 1'b0;
				end
			end
		end
	end

	always_comb begin
		acc_nx = acc_q;
		acc_nx[8 * k_q[2:0] +: 8] = rdata_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			len_q          <= LEN_RESET;
			wp_q           <= '0;
			rp_q           <= '0;
			fill_q         <= '0;
			addr_q         <= '0;
			iss_q          <= '0;
			k_q            <= '0;
			n_q            <= '0;
			pat_q          <= '0;
			acc_q          <= '0;
			valid_s1       <= 1'b0;
			done_q         <= 1'b0;
			status_q       <= STAT_OK;
			read_bytes_q   <= '0;
			bytes_read_q   <= '0;
			match_offset_q <= '0;
			fill_level_q   <= '0;
			for (int j = 0; j < MAX_BYTES; j++) begin
				win_q[j] <= '0;
			end
		end else begin
			done_q   <= 1'b0;
			valid_s1 <= issue;
			if (issue) begin
				addr_q <= ptr_next(addr_q, len_eff);
				iss_q  <= iss_q - addr_t'(1);
			end

			// A length write empties the FIFO; the user must write it only while idle, the block does not enforce it.
			if (cfg_we) begin
				len_q  <= cfg_wdata;
				wp_q   <= '0;
				rp_q   <= '0;
				fill_q <= '0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						read_bytes_q   <= '0;
						bytes_read_q   <= '0;
						match_offset_q <= '0;
						fill_level_q   <= fill_q;
						status_q       <= STAT_OK;
						pat_q          <= payload;
						n_q            <= n_eff;
						k_q            <= '0;
						acc_q          <= '0;
						addr_q         <= rp_q;
						if (!(cmd inside {CMD_PUT, CMD_GET, CMD_FIND})) begin
							done_q <= 1'b1;
						end else if (n_eff == CNT_W'(0)) begin
							status_q <= STAT_ZERO_LEN;
							done_q   <= 1'b1;
						end else if (cmd == CMD_PUT) begin
							if ({5'b0, n_eff} > room) begin
								status_q <= STAT_OVERFLOW;
								done_q   <= 1'b1;
							end else begin
								state_q <= S_PUT;
							end
						end else if (cmd == CMD_GET) begin
							if (get_n == CNT_W'(0)) begin
								done_q <= 1'b1;
							end else begin
								n_q     <= get_n;
								iss_q   <= addr_t'(get_n);
								state_q <= S_GET;
							end
						end else begin
							if ({4'b0, n_eff} > fill_q) begin
								status_q <= STAT_NOTFOUND;
								done_q   <= 1'b1;
							end else begin
								iss_q   <= fill_q;
								state_q <= S_FIND;
							end
						end
					end
				end
				S_PUT: begin
					// One byte written per cycle, lowest payload byte first.
					wp_q  <= ptr_next(wp_q, len_eff);
					pat_q <= {8'b0, pat_q[DATA_W-1:8]};
					k_q   <= k_inc[ADDR_W-1:0];
					if (k_next == n_q) begin
						fill_q       <= fill_q + addr_t'(n_q);
						fill_level_q <= fill_q + addr_t'(n_q);
						done_q       <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_GET: begin
					if (valid_s1) begin
						acc_q <= acc_nx;
						k_q   <= k_inc[ADDR_W-1:0];
						if (k_next == n_q) begin
							read_bytes_q <= acc_nx;
							bytes_read_q <= n_q;
							rp_q         <= addr_q;
							fill_q       <= fill_q - addr_t'(n_q);
							fill_level_q <= fill_q - addr_t'(n_q);
							done_q       <= 1'b1;
							state_q      <= S_IDLE;
						end
					end
				end
				S_FIND: begin
					if (valid_s1) begin
						for (int j = 0; j < MAX_BYTES; j++) begin
							win_q[j] <= win_nx[j];
						end
						k_q <= k_inc[ADDR_W-1:0];
						if ((k_inc >= {5'b0, n_q}) && win_match) begin
							match_offset_q <= ADDR_W'(k_inc - {5'b0, n_q});
							done_q         <= 1'b1;
							state_q        <= S_IDLE;
						end else if (k_inc == {1'b0, fill_q}) begin
							status_q <= STAT_NOTFOUND;
							done_q   <= 1'b1;
							state_q  <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign read_bytes   = read_bytes_q;
	assign bytes_read   = bytes_read_q;
	assign match_offset = match_offset_q;
	assign fill_level   = fill_level_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
`include "byte_ring_fifo_with_search_unit_assert.svh"

	// The fill count never reaches the active length: one slot stays empty.
	`BRFS_ASSERT_ALWAYS(a_fill_below_len, clk, arst_n, ({1'b0, fill_q} < len_eff))

	// While idle, the fill count agrees with the pointer distance.
	`BRFS_ASSERT_SAME(a_fill_matches_ptrs, clk, arst_n, (state_q == S_IDLE),
		(fill_q == ((wp_q >= rp_q) ? (wp_q - rp_q) : ADDR_W'(len_eff - {1'b0, rp_q - wp_q}))))

	// An accepted command either reports at once or keeps the block busy.
	`BRFS_ASSERT_NEXT(a_accept_progress, clk, arst_n, accept, (done || busy))

endmodule
